FILE: rtl/acbc_pkg.sv
// Shared types, constants and helpers for the alarm clock button controller.
package acbc_pkg;

    // Poll beat, one per input handshake
    typedef struct packed {
        logic [63:0] now_us;
        logic        btn_hour_n;
        logic        btn_minute_n;
        logic        btn_second_n;
        logic        btn_alarm_n;
        logic        clear_offsets;
        logic [4:0]  cur_hours;
        logic [5:0]  cur_minutes;
        logic [5:0]  cur_seconds;
    } poll_t;

    // Status beat, one per poll
    typedef struct packed {
        logic        led_on;
        logic        setting_mode;
        logic        armed;
        logic        ringing;
        logic [4:0]  alarm_hour_out;
        logic [5:0]  alarm_minute_out;
        logic [5:0]  alarm_second_out;
        logic [4:0]  offset_hour_out;
        logic [5:0]  offset_minute_out;
        logic [5:0]  offset_second_out;
    } result_t;

    // Button slots in the last-press store
    localparam int NUM_KEYS   = 4;
    localparam int KEY_HOUR   = 0;
    localparam int KEY_MINUTE = 1;
    localparam int KEY_SECOND = 2;
    localparam int KEY_ALARM  = 3;

    localparam logic [5:0]  HOURS_PER_DAY  = 6'd24;
    localparam logic [5:0]  UNITS_PER_MIN  = 6'd60;
    localparam logic [31:0] DEBOUNCE_RESET = 32'd200000;

    // Blink half period 500000 = 2^5 * 15625; the odd factor is handled by residues
    localparam int          BLINK_SHIFT = 5;
    localparam logic [63:0] BLINK_ODD   = 64'd15625;

    // Residues of 2^16, 2^32 and 2^48 modulo the odd factor
    localparam logic [63:0] MOD_C1 = (64'd1 << 16) % BLINK_ODD;
    localparam logic [63:0] MOD_C2 = (MOD_C1 * MOD_C1) % BLINK_ODD;
    localparam logic [63:0] MOD_C3 = (MOD_C2 * MOD_C1) % BLINK_ODD;

    // Reciprocal for an exact floor divide of a 31-bit value by the odd factor
    localparam int          RECIP_SHIFT = 45;
    localparam logic [63:0] RECIP = ((64'd1 << RECIP_SHIFT) + BLINK_ODD - 64'd1) / BLINK_ODD;

    // Increment with wrap to zero at the modulus
    function automatic logic [5:0] step_wrap(input logic [5:0] v, input logic [5:0] modulus);
        logic [6:0] n;
        n = {1'b0, v} + 7'd1;
        return (n >= {1'b0, modulus}) ? 6'd0 : n[5:0];
    endfunction

endpackage

FILE: rtl/alarm_clock_button_controller.sv
// Alarm clock button controller: blink phase pipeline and per-poll state update.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one poll beat: timestamp,
//   four active-low button levels, clear-offsets flag and the displayed time.
//   out channel (out_valid/out_ready/out_data) gives one status beat per
//   poll, in order: LED, mode flags, alarm time and clock offsets.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the debounce time in
//   microseconds; cfg_ready is always high. Write it only while idle.
// Timing:
//   An accepted poll passes through the stage registers into the output
//   register. One poll per cycle is sustained while out_ready is high.
//   The first three stages work out the blink phase floor(now_us/500000)
//   mod 2 through residue products and a reciprocal multiply; the fourth
//   stage applies the debounce compares and updates the alarm and offset
//   state as the beat moves to the output register.
// Reset:
//   Clears all stage valids, the last-press times, alarm, offsets, flags and
//   LED; the debounce time returns to 200000 us.
// Stall:
//   While out_ready is low the result holds; polls still enter until every
//   stage is full, then in_ready drops.
module alarm_clock_button_controller
    import acbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  poll_t       in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    // Stage valids and flow control
    logic st0_v_reg, st1_v_reg, st2_v_reg, st3_v_reg, out_v_reg;
    logic rdy0, rdy1, rdy2, rdy3, out_free, fire;

    // Stage payloads
    poll_t       st0_poll_reg, st1_poll_reg, st2_poll_reg, st3_poll_reg;
    logic [15:0] st1_a0_reg;
    logic [29:0] st1_p1_reg, st1_p2_reg;
    logic [24:0] st1_p3_reg;
    logic        st1_x0_reg, st2_x0_reg;
    logic [30:0] st2_sum_reg;
    logic        st3_odd_reg;
    result_t     out_reg;

    // Block state
    logic [31:0] debounce_reg;
    logic [63:0] last_reg [NUM_KEYS];
    logic [63:0] last_next [NUM_KEYS];
    logic [4:0]  alarm_h_reg, alarm_h_next, off_h_reg, off_h_next;
    logic [5:0]  alarm_m_reg, alarm_m_next, off_m_reg, off_m_next;
    logic [5:0]  alarm_s_reg, alarm_s_next, off_s_reg, off_s_next;
    logic        set_reg, set_next, armed_reg, armed_next;
    logic        ring_reg, ring_next, led_reg, led_next;

    // Blink phase datapath signals
    logic [58:0] x0_w;
    logic [62:0] prod_w;
    logic [NUM_KEYS-1:0] lvl_n, press;
    logic [63:0] gap [NUM_KEYS];
    result_t     result_w;

    assign out_free  = !out_v_reg || out_ready;
    assign rdy3      = !st3_v_reg || out_free;
    assign rdy2      = !st2_v_reg || rdy3;
    assign rdy1      = !st1_v_reg || rdy2;
    assign rdy0      = !st0_v_reg || rdy1;
    assign in_ready  = rdy0;
    assign fire      = st3_v_reg && out_free;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st0_v_reg <= 1'b0;
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                st0_v_reg <= in_valid;
            if (rdy1)
                st1_v_reg <= st0_v_reg;
            if (rdy2)
                st2_v_reg <= st1_v_reg;
            if (rdy3)
                st3_v_reg <= st2_v_reg;
            if (out_free)
                out_v_reg <= st3_v_reg;
        end
    end

    // Split the timestamp past the power-of-two factor into 16-bit chunks, the top one 11 bits wide
    assign x0_w = st0_poll_reg.now_us[63:BLINK_SHIFT];

    // Reciprocal multiply of the folded residue sum
    assign prod_w = 63'({st2_sum_reg, 32'd0} >> 32) * 63'(32'(RECIP));

    // Move payloads and blink phase terms down the pipe
    always_ff @(posedge clk)
    begin
        if (rdy0)
            st0_poll_reg <= in_data;
        if (rdy1)
        begin
            st1_poll_reg <= st0_poll_reg;
            st1_a0_reg   <= x0_w[15:0];
            st1_p1_reg   <= 30'(x0_w[31:16]) * 30'(14'(MOD_C1));
            st1_p2_reg   <= 30'(x0_w[47:32]) * 30'(14'(MOD_C2));
            st1_p3_reg   <= 25'(x0_w[58:48]) * 25'(14'(MOD_C3));
            st1_x0_reg   <= x0_w[0];
        end
        if (rdy2)
        begin
            st2_poll_reg <= st1_poll_reg;
            st2_sum_reg  <= 31'(st1_a0_reg) + 31'(st1_p1_reg) + 31'(st1_p2_reg)
                          + 31'(st1_p3_reg);
            st2_x0_reg   <= st1_x0_reg;
        end
        if (rdy3)
        begin
            st3_poll_reg <= st2_poll_reg;
            // Quotient parity: timestamp bit, residue bit and folded quotient bit
            st3_odd_reg  <= st2_x0_reg ^ st2_sum_reg[0] ^ prod_w[RECIP_SHIFT];
        end
        if (out_free && st3_v_reg)
            out_reg <= result_w;
    end

    // Debounce each button against its last accepted press
    always_comb
    begin
        lvl_n[KEY_HOUR]   = st3_poll_reg.btn_hour_n;
        lvl_n[KEY_MINUTE] = st3_poll_reg.btn_minute_n;
        lvl_n[KEY_SECOND] = st3_poll_reg.btn_second_n;
        lvl_n[KEY_ALARM]  = st3_poll_reg.btn_alarm_n;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            gap[k]       = st3_poll_reg.now_us - last_reg[k];
            press[k]     = !lvl_n[k] && (gap[k] > {32'd0, debounce_reg});
            last_next[k] = press[k] ? st3_poll_reg.now_us : last_reg[k];
        end
    end

    // Apply clear, alarm button, step buttons, alarm compare and blink
    always_comb
    begin
        off_h_next   = off_h_reg;
        off_m_next   = off_m_reg;
        off_s_next   = off_s_reg;
        alarm_h_next = alarm_h_reg;
        alarm_m_next = alarm_m_reg;
        alarm_s_next = alarm_s_reg;
        set_next     = set_reg;
        armed_next   = armed_reg;
        ring_next    = ring_reg;
        led_next     = led_reg;

        if (st3_poll_reg.clear_offsets)
        begin
            off_h_next = 5'd0;
            off_m_next = 6'd0;
            off_s_next = 6'd0;
        end

        // Alarm button cycles: dismiss, arm, start setting
        if (press[KEY_ALARM])
        begin
            priority if (ring_reg)
            begin
                ring_next = 1'b0;
                led_next  = 1'b0;
            end
            else if (set_reg)
            begin
                set_next   = 1'b0;
                armed_next = 1'b1;
            end
            else
            begin
                set_next     = 1'b1;
                armed_next   = 1'b0;
                ring_next    = 1'b0;
                alarm_h_next = 5'd0;
                alarm_m_next = 6'd0;
                alarm_s_next = 6'd0;
            end
        end

        // Step alarm time while setting, else the clock offsets
        if (set_next)
        begin
            if (press[KEY_HOUR])
                alarm_h_next = 5'(step_wrap({1'b0, alarm_h_next}, HOURS_PER_DAY));
            if (press[KEY_MINUTE])
                alarm_m_next = step_wrap(alarm_m_next, UNITS_PER_MIN);
            if (press[KEY_SECOND])
                alarm_s_next = step_wrap(alarm_s_next, UNITS_PER_MIN);
        end
        else
        begin
            if (press[KEY_HOUR])
                off_h_next = 5'(step_wrap({1'b0, off_h_next}, HOURS_PER_DAY));
            if (press[KEY_MINUTE])
                off_m_next = step_wrap(off_m_next, UNITS_PER_MIN);
            if (press[KEY_SECOND])
                off_s_next = step_wrap(off_s_next, UNITS_PER_MIN);
        end

        // Trigger on a time match
        if (armed_next && !ring_next &&
            st3_poll_reg.cur_hours == alarm_h_next &&
            st3_poll_reg.cur_minutes == alarm_m_next &&
            st3_poll_reg.cur_seconds == alarm_s_next)
            ring_next = 1'b1;

        // Blink on even half periods
        if (ring_next)
            led_next = !st3_odd_reg;

        result_w.led_on            = led_next;
        result_w.setting_mode      = set_next;
        result_w.armed             = armed_next;
        result_w.ringing           = ring_next;
        result_w.alarm_hour_out    = alarm_h_next;
        result_w.alarm_minute_out  = alarm_m_next;
        result_w.alarm_second_out  = alarm_s_next;
        result_w.offset_hour_out   = off_h_next;
        result_w.offset_minute_out = off_m_next;
        result_w.offset_second_out = off_s_next;
    end

    // Hold debounce setting and block state; update on each finished poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            for (int k = 0; k < NUM_KEYS; k++)
                last_reg[k] <= 64'd0;
            off_h_reg   <= 5'd0;
            off_m_reg   <= 6'd0;
            off_s_reg   <= 6'd0;
            alarm_h_reg <= 5'd0;
            alarm_m_reg <= 6'd0;
            alarm_s_reg <= 6'd0;
            set_reg     <= 1'b0;
            armed_reg   <= 1'b0;
            ring_reg    <= 1'b0;
            led_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                debounce_reg <= cfg_data;
            if (fire)
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                    last_reg[k] <= last_next[k];
                off_h_reg   <= off_h_next;
                off_m_reg   <= off_m_next;
                off_s_reg   <= off_s_next;
                alarm_h_reg <= alarm_h_next;
                alarm_m_reg <= alarm_m_next;
                alarm_s_reg <= alarm_s_next;
                set_reg     <= set_next;
                armed_reg   <= armed_next;
                ring_reg    <= ring_next;
                led_reg     <= led_next;
            end
        end
    end

endmodule

FILE: test/acbc_status_checker.sv
// Status checker for the alarm clock button controller: tracks polls, predicts and compares.
`timescale 1ns / 100ps

module acbc_status_checker
    import acbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  poll_t       in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  result_t     out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          failures,
    output int          outstanding,
    output int          results_checked
);

    localparam logic [63:0] BLINK_HALF_US = 64'd500000;

    // Shadow of the block's state
    logic [63:0] last_press [NUM_KEYS];
    logic [31:0] debounce;
    logic [5:0]  off_h, off_m, off_s;
    logic [5:0]  al_h, al_m, al_s;
    logic        setting_q, armed_q, ringing_q, led_q;

    result_t     pending_status [$];
    result_t     want;
    int          mismatches;
    int          checked;

    // Accept a held key once the gap since its last accepted press exceeds the debounce time
    function automatic logic press_taken(input int key, input logic level_n,
                                         input logic [63:0] stamp);
        if (level_n)
            return 1'b0;
        if ((stamp - last_press[key]) <= {32'd0, debounce})
            return 1'b0;
        last_press[key] = stamp;
        return 1'b1;
    endfunction

    // Advance a counter and wrap to zero at the modulus
    function automatic logic [5:0] bump(input logic [5:0] v, input logic [5:0] modulus);
        logic [6:0] n;
        n = {1'b0, v} + 7'd1;
        if (n >= {1'b0, modulus})
            return 6'd0;
        return n[5:0];
    endfunction

    // Apply one poll to the shadow state and return the status it produces
    function automatic result_t poll_outcome(input poll_t p);
        result_t r;
        if (p.clear_offsets) begin
            off_h = '0;
            off_m = '0;
            off_s = '0;
        end
        if (press_taken(KEY_ALARM, p.btn_alarm_n, p.now_us)) begin
            if (ringing_q) begin
                ringing_q = 1'b0;
                led_q     = 1'b0;
            end
            else if (setting_q) begin
                setting_q = 1'b0;
                armed_q   = 1'b1;
            end
            else begin
                setting_q = 1'b1;
                armed_q   = 1'b0;
                ringing_q = 1'b0;
                al_h      = '0;
                al_m      = '0;
                al_s      = '0;
            end
        end
        if (setting_q) begin
            if (press_taken(KEY_HOUR, p.btn_hour_n, p.now_us))
                al_h = bump(al_h, HOURS_PER_DAY);
            if (press_taken(KEY_MINUTE, p.btn_minute_n, p.now_us))
                al_m = bump(al_m, UNITS_PER_MIN);
            if (press_taken(KEY_SECOND, p.btn_second_n, p.now_us))
                al_s = bump(al_s, UNITS_PER_MIN);
        end
        else begin
            if (press_taken(KEY_HOUR, p.btn_hour_n, p.now_us))
                off_h = bump(off_h, HOURS_PER_DAY);
            if (press_taken(KEY_MINUTE, p.btn_minute_n, p.now_us))
                off_m = bump(off_m, UNITS_PER_MIN);
            if (press_taken(KEY_SECOND, p.btn_second_n, p.now_us))
                off_s = bump(off_s, UNITS_PER_MIN);
        end
        // Ring on a time match, then blink with the half-second phase
        if (armed_q && !ringing_q && {1'b0, p.cur_hours} == al_h &&
            p.cur_minutes == al_m && p.cur_seconds == al_s)
            ringing_q = 1'b1;
        if (ringing_q)
            led_q = ((p.now_us / BLINK_HALF_US) & 64'd1) == 64'd0;

        r.led_on            = led_q;
        r.setting_mode      = setting_q;
        r.armed             = armed_q;
        r.ringing           = ringing_q;
        r.alarm_hour_out    = al_h[4:0];
        r.alarm_minute_out  = al_m;
        r.alarm_second_out  = al_s;
        r.offset_hour_out   = off_h[4:0];
        r.offset_minute_out = off_m;
        r.offset_second_out = off_s;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [5:0] got,
                               input logic [5:0] exp_val);
        if (got !== exp_val) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: status field %s expected %0d, got %0d",
                         $time, field, exp_val, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++)
                last_press[k] = '0;
            debounce  = DEBOUNCE_RESET;
            off_h     = '0;
            off_m     = '0;
            off_s     = '0;
            al_h      = '0;
            al_m      = '0;
            al_s      = '0;
            setting_q = 1'b0;
            armed_q   = 1'b0;
            ringing_q = 1'b0;
            led_q     = 1'b0;
            pending_status.delete();
            mismatches = 0;
            checked    = 0;
            outstanding     <= 0;
            failures        <= 0;
            results_checked <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                debounce = cfg_data;
            if (in_valid && in_ready)
                pending_status.push_back(poll_outcome(in_data));
            // Compare each status beat against the oldest prediction
            if (out_valid && out_ready) begin
                if (pending_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: status beat %h arrived with no poll pending",
                                 $time, out_data);
                end
                else begin
                    want = pending_status.pop_front();
                    check_field("led_on", {5'd0, out_data.led_on}, {5'd0, want.led_on});
                    check_field("setting_mode", {5'd0, out_data.setting_mode},
                                {5'd0, want.setting_mode});
                    check_field("armed", {5'd0, out_data.armed}, {5'd0, want.armed});
                    check_field("ringing", {5'd0, out_data.ringing}, {5'd0, want.ringing});
                    check_field("alarm_hour_out", {1'b0, out_data.alarm_hour_out},
                                {1'b0, want.alarm_hour_out});
                    check_field("alarm_minute_out", out_data.alarm_minute_out,
                                want.alarm_minute_out);
                    check_field("alarm_second_out", out_data.alarm_second_out,
                                want.alarm_second_out);
                    check_field("offset_hour_out", {1'b0, out_data.offset_hour_out},
                                {1'b0, want.offset_hour_out});
                    check_field("offset_minute_out", out_data.offset_minute_out,
                                want.offset_minute_out);
                    check_field("offset_second_out", out_data.offset_second_out,
                                want.offset_second_out);
                    checked++;
                end
            end
            outstanding     <= pending_status.size();
            failures        <= mismatches;
            results_checked <= checked;
        end
    end

endmodule

FILE: test/testbench.sv
// Top of the alarm clock button controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench
    import acbc_pkg::*;
();

    // Button hold masks for building polls
    localparam logic [3:0] HOLD_NONE   = 4'b0000;
    localparam logic [3:0] HOLD_HOUR   = 4'b0001;
    localparam logic [3:0] HOLD_MINUTE = 4'b0010;
    localparam logic [3:0] HOLD_SECOND = 4'b0100;
    localparam logic [3:0] HOLD_ALARM  = 4'b1000;
    localparam logic [3:0] HOLD_ALL    = 4'b1111;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    poll_t       in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    result_t     out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    int          failures;
    int          outstanding;
    int          results_checked;

    logic [63:0] clock_now    = '0;
    logic [31:0] debounce_now = DEBOUNCE_RESET;
    result_t     latest_status = '0;
    int          sent          = 0;
    int          rx_beats      = 0;
    int          ringing_beats = 0;
    logic        tx_quiet      = 1'b0;
    logic        rx_quiet      = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    alarm_clock_button_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    acbc_status_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    function automatic poll_t make_poll(input logic [63:0] stamp, input logic [3:0] held,
                                       input logic clr, input logic [4:0] ch,
                                       input logic [5:0] cm, input logic [5:0] cs);
        poll_t p;
        p.now_us        = stamp;
        p.btn_hour_n    = (held & HOLD_HOUR) == HOLD_NONE;
        p.btn_minute_n  = (held & HOLD_MINUTE) == HOLD_NONE;
        p.btn_second_n  = (held & HOLD_SECOND) == HOLD_NONE;
        p.btn_alarm_n   = (held & HOLD_ALARM) == HOLD_NONE;
        p.clear_offsets = clr;
        p.cur_hours     = ch;
        p.cur_minutes   = cm;
        p.cur_seconds   = cs;
        return p;
    endfunction

    // Advance the poll clock: mostly forward around the debounce time, sometimes backward or wild
    function automatic logic [63:0] next_stamp();
        int unsigned pick;
        logic [63:0] span;
        pick = $urandom_range(0, 99);
        span = {32'd0, debounce_now} + 64'd1000;
        if (pick < 70)
            clock_now = clock_now + ((span * {32'd0, $urandom_range(0, 3)}) >> 1);
        else if (pick < 80)
            clock_now = clock_now + {32'd0, $urandom_range(0, 1000000)};
        else if (pick < 88)
            clock_now = clock_now + {32'd0, debounce_now} + {32'd0, $urandom_range(0, 1)};
        else if (pick < 94)
            clock_now = clock_now - {32'd0, $urandom_range(1, 1000000)};
        else if (pick < 97)
            clock_now = {$urandom, $urandom};
        else
            clock_now = 64'hFFFF_FFFF_FFFF_FFFF - {32'd0, $urandom_range(0, 400000)};
        return clock_now;
    endfunction

    // Step safely past the debounce window
    function automatic logic [63:0] spaced_stamp();
        clock_now = clock_now + {32'd0, debounce_now} + 64'd1 +
                    {32'd0, $urandom_range(0, 300000)};
        return clock_now;
    endfunction

    function automatic poll_t random_poll();
        logic [3:0]  held;
        logic [31:0] rnd;
        int unsigned pick;
        logic [4:0]  ch;
        logic [5:0]  cm, cs;
        held = HOLD_NONE;
        if ($urandom_range(0, 99) < 40) held = held | HOLD_HOUR;
        if ($urandom_range(0, 99) < 40) held = held | HOLD_MINUTE;
        if ($urandom_range(0, 99) < 40) held = held | HOLD_SECOND;
        if ($urandom_range(0, 99) < 25) held = held | HOLD_ALARM;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            rnd = $urandom_range(0, 2);
            ch  = rnd[4:0];
            rnd = $urandom_range(0, 2);
            cm  = rnd[5:0];
            rnd = $urandom_range(0, 2);
            cs  = rnd[5:0];
        end
        else if (pick < 85) begin
            rnd = $urandom_range(0, 23);
            ch  = rnd[4:0];
            rnd = $urandom_range(0, 59);
            cm  = rnd[5:0];
            rnd = $urandom_range(0, 59);
            cs  = rnd[5:0];
        end
        else begin
            rnd = $urandom;
            ch  = rnd[4:0];
            cm  = rnd[10:5];
            cs  = rnd[16:11];
        end
        return make_poll(next_stamp(), held, $urandom_range(0, 99) < 4, ch, cm, cs);
    endfunction

    // Present one poll beat after a random gap and hold it until taken
    task automatic send(input poll_t p);
        int unsigned gap;
        if (sent % 40 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Drop valid and hold off until every predicted status beat has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic load_debounce(input logic [31:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        debounce_now = value;
    endtask

    task automatic random_polls(input int count);
        repeat (count) send(random_poll());
    endtask

    // Walk the alarm into setting mode, then hold the time keys long enough to wrap
    task automatic setting_run();
        poll_t p;
        logic [3:0] held;
        settle();
        for (int tries = 0; tries < 4 && !latest_status.setting_mode; tries++) begin
            send(make_poll(spaced_stamp(), HOLD_ALARM, 1'b0, 5'd0, 6'd0, 6'd0));
            settle();
        end
        repeat ($urandom_range(30, 80)) begin
            held = HOLD_NONE;
            if ($urandom_range(0, 99) < 80) held = held | HOLD_HOUR;
            if ($urandom_range(0, 99) < 90) held = held | HOLD_MINUTE;
            if ($urandom_range(0, 99) < 90) held = held | HOLD_SECOND;
            p = make_poll(spaced_stamp(), held, 1'b0, 5'd31, 6'd63, 6'd63);
            send(p);
        end
    endtask

    // Arm, present the alarm time, let it blink, dismiss once on a match and once off it
    task automatic ring_run();
        logic [4:0] th;
        logic [5:0] tm, ts;
        send(make_poll(spaced_stamp(), HOLD_ALARM, 1'b0, 5'd31, 6'd63, 6'd63));
        settle();
        th = latest_status.alarm_hour_out;
        tm = latest_status.alarm_minute_out;
        ts = latest_status.alarm_second_out;
        repeat ($urandom_range(3, 8))
            send(make_poll(spaced_stamp(), HOLD_NONE, 1'b0, th, tm, ts));
        send(make_poll(spaced_stamp(), HOLD_ALARM, 1'b0, th, tm, ts));
        send(make_poll(spaced_stamp(), HOLD_ALARM, 1'b0, th ^ 5'd1, tm, ts));
    endtask

    // Accept status beats with random stalls
    initial begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_beats % 50 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            latest_status = out_data;
            if (out_data.ringing)
                ringing_beats++;
            rx_beats++;
        end
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [31:0] settings [6];
        settings[0] = 32'd0;
        settings[1] = 32'd1000;
        settings[2] = 32'hFFFF_FFFF;
        settings[3] = 32'd1;
        settings[4] = DEBOUNCE_RESET;
        settings[5] = $urandom_range(2, 2000000);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Early presses are swallowed, then exactly the debounce gap is still too short
        send(make_poll(64'd0, HOLD_ALL, 1'b0, 5'd0, 6'd0, 6'd0));
        send(make_poll(64'd200000, HOLD_ALL, 1'b0, 5'd0, 6'd0, 6'd0));
        // Enter setting and step the alarm to 1:01:01
        send(make_poll(64'd200001, HOLD_ALL, 1'b0, 5'd0, 6'd0, 6'd0));
        send(make_poll(64'd200002, HOLD_NONE, 1'b0, 5'd1, 6'd1, 6'd1));
        // Arm on a matching time, ring and blink
        send(make_poll(64'd400002, HOLD_ALARM, 1'b0, 5'd1, 6'd1, 6'd1));
        send(make_poll(64'd500000, HOLD_NONE, 1'b0, 5'd0, 6'd0, 6'd0));
        send(make_poll(64'd1000000, HOLD_NONE, 1'b0, 5'd0, 6'd0, 6'd0));
        // Dismiss while still matching rings again; dismiss off the match goes quiet
        send(make_poll(64'd1000001, HOLD_ALARM, 1'b0, 5'd1, 6'd1, 6'd1));
        send(make_poll(64'd1300000, HOLD_ALARM, 1'b0, 5'd2, 6'd2, 6'd2));
        // Offsets step while armed, then clear
        send(make_poll(64'd1300001, HOLD_HOUR, 1'b0, 5'd2, 6'd2, 6'd2));
        send(make_poll(64'd1300002, HOLD_MINUTE | HOLD_SECOND, 1'b0, 5'd2, 6'd2, 6'd2));
        send(make_poll(64'd1300003, HOLD_HOUR, 1'b1, 5'd2, 6'd2, 6'd2));
        // Out-of-range displayed time never triggers
        send(make_poll(64'd1300004, HOLD_NONE, 1'b0, 5'd31, 6'd63, 6'd63));
        // Backward timestamp looks like a huge gap
        send(make_poll(64'd5, HOLD_ALARM, 1'b0, 5'd31, 6'd63, 6'd63));
        // Top of the timestamp range, then wrap past zero
        send(make_poll(64'hFFFF_FFFF_FFFF_FFFF, HOLD_ALL, 1'b0, 5'd0, 6'd0, 6'd0));
        send(make_poll(64'd200000, HOLD_ALL, 1'b1, 5'd0, 6'd0, 6'd0));
        send(make_poll(64'hAAAA_AAAA_AAAA_AAAA, HOLD_NONE, 1'b0, 5'd21, 6'd42, 6'd42));
        send(make_poll(64'h5555_5555_5555_5555, HOLD_ALL, 1'b1, 5'd10, 6'd21, 6'd21));
        clock_now = 64'h5555_5555_5555_5555;

        // Reset debounce first, then every other setting
        random_polls(110);
        setting_run();
        ring_run();
        for (int k = 0; k < 6; k++) begin
            load_debounce(settings[k]);
            random_polls(110);
            setting_run();
            ring_run();
        end

        settle();
        repeat (8) @(posedge clk);

        $display("Sent %0d polls under seven debounce settings, from 0 up to all ones.",
                 sent);
        $display("Checked %0d status beats, %0d of them with the alarm ringing.",
                 results_checked, ringing_beats);
        if (failures == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
rtl/acbc_pkg.sv
rtl/alarm_clock_button_controller.sv
test/acbc_status_checker.sv
test/testbench.sv
